// File: rtl/stereo_pan_gain_smoother_meter_top_macros.svh
// Assertion macros for the stereo pan, gain, smoother and meter block.
`ifndef STEREO_PAN_GAIN_SMOOTHER_METER_TOP_MACROS_SVH
`define STEREO_PAN_GAIN_SMOOTHER_METER_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define SPGSM_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every rising clock edge outside reset.
`define SPGSM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPGSM_ASSERT_IMPL(name, ante, cons, msg)
`define SPGSM_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// File: rtl/spgsm_pkg.sv
// Shared types and constants of the stereo pan, gain, smoother and meter block.
package spgsm_pkg;

  localparam int unsigned GAIN_W     = 18;
  localparam int unsigned COEF_W     = 18;
  localparam int unsigned SINE_W     = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0]        VOLUME_RESET = 16'd16384;
  localparam logic [COEF_W-1:0]  SMOOTH_COEF  = 18'd655;
  localparam logic [COEF_W-1:0]  DECAY_COEF   = 18'd65208;
  localparam longint unsigned    HALF_PI_Q30  = 64'd1686629713;
  localparam longint unsigned    SINE_CAP     = 64'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLUME     = 3'd0,
    REG_PAN        = 3'd1,
    REG_MUTE       = 3'd2,
    REG_SOLO_COUNT = 3'd3,
    REG_SELF_SOLO  = 3'd4
  } spgsm_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TGT_R,
    ST_TGT_L,
    ST_SM_R,
    ST_SM_L,
    ST_SC_R,
    ST_SC_L,
    ST_MT_R,
    ST_MT_L,
    ST_MT_FIN,
    ST_OUT
  } spgsm_state_e;

endpackage

// File: rtl/spgsm_if.sv
// Valid/ready stream interfaces for the sample pair input and the result output.
interface spgsm_in_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          block_last;

  modport source (output valid, left_in, right_in, block_last, input ready);
  modport sink   (input valid, left_in, right_in, block_last, output ready);
endinterface

interface spgsm_out_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic        [SAMPLE_BITS-2:0] meter_left;
  logic        [SAMPLE_BITS-2:0] meter_right;

  modport source (output valid, left_out, right_out, meter_left, meter_right, input ready);
  modport sink   (input valid, left_out, right_out, meter_left, meter_right, output ready);
endinterface

// File: rtl/spgsm_mul.sv
// Shared unsigned multiplier with a registered product.
module spgsm_mul #(
  parameter int unsigned A_W = 24,
  parameter int unsigned B_W = 18
) (
  input  logic               clk_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] p_o
);

  logic [A_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (A_W+B_W)'(a_i) * (A_W+B_W)'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: rtl/stereo_pan_gain_smoother_meter_top.sv
// Top level of the equal-power pan and gain stage with gain smoothing and peak meters.
//
// One input beat carries a stereo sample pair and a block_last flag; one output beat
// carries the gained left and right samples and both held peak meters. Both channels
// use valid/ready; a beat moves when valid and ready are high at a rising clock edge.
// Configuration (volume, pan, mute, solo count, self solo) is written through a plain
// write port and must only change while the block is idle.
// A new pair is accepted only once the sequencer is idle again; a pair with block_last
// set takes extra steps to update the meters. All multiplies of samples, gains and
// meters go through one registered multiplier, which a sequencer uses seven times per
// pair (eight on a block end), so that multiplier sets the rate.
// The output is a register of its own: the next pair is accepted while a result still
// waits. If the receiver stalls, the sequencer holds its finished result in the last
// step until the output register frees up, and accepts nothing more meanwhile.
// Reset clears the smoothed gains, peaks and meters to zero and loads the register
// defaults (unity volume, center pan, no mute, no solo). The sine table is a constant
// ROM built at elaboration, so no clearing pass follows reset.
`include "stereo_pan_gain_smoother_meter_top_macros.svh"

module stereo_pan_gain_smoother_meter_top
  import spgsm_pkg::*;
#(
  parameter int unsigned PAN_TABLE_ENTRIES = 256,
  parameter int unsigned SAMPLE_BITS       = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  spgsm_in_if.sink              in_i,
  spgsm_out_if.source           out_o
);

  localparam int unsigned IW   = $clog2(PAN_TABLE_ENTRIES + 1);
  localparam int unsigned AW   = (SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W;
  localparam int unsigned PW   = AW + COEF_W;
  localparam int unsigned PPW  = PW - 15;
  localparam int unsigned MW   = SAMPLE_BITS - 1;
  localparam logic [MW-1:0]  SMAX_M = {MW{1'b1}};
  localparam logic [PPW-1:0] SMAX_P = PPW'(SMAX_M);

  // Sine point k of the quarter wave, Q1.16, from a truncated Taylor series in Q2.30.
  function automatic logic [SINE_W-1:0] sine_point(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned q;
    longint          sum;
    x    = (HALF_PI_Q30 * 64'(k)) / PAN_TABLE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    q = ($unsigned(sum) + 64'd8192) >> 14;
    if (q > SINE_CAP) begin
      q = SINE_CAP;
    end
    return q[SINE_W-1:0];
  endfunction

  // One smoothing step: round the scaled distance, move at least one LSB toward target.
  function automatic logic [GAIN_W-1:0] smooth_step(input logic [GAIN_W-1:0] g,
                                                    input logic [GAIN_W-1:0] t,
                                                    input logic [27:0]       p);
    logic [28:0]       rs;
    logic [GAIN_W-1:0] s;
    rs = {1'b0, p} + 29'd32768;
    s  = GAIN_W'(rs[28:16]);
    if (s == '0) begin
      s = GAIN_W'(1);
    end
    if (t == g) begin
      return g;
    end else if (t > g) begin
      return g + s;
    end else begin
      return g - s;
    end
  endfunction

  // Constant sine ROM with one registered read port.
  logic [SINE_W-1:0] sine_rom [PAN_TABLE_ENTRIES+1];

  for (genvar k = 0; k <= PAN_TABLE_ENTRIES; k++) begin : g_rom
    localparam logic [SINE_W-1:0] Point = sine_point(k);
    assign sine_rom[k] = Point;
  end

  spgsm_state_e state_q, state_d;

  logic [15:0] vol_q;
  logic [15:0] pan_q;
  logic        mute_q;
  logic [7:0]  solo_q;
  logic        self_solo_q;

  logic [SAMPLE_BITS-1:0] smp_l_q, smp_r_q;
  logic                   last_q;
  logic [GAIN_W-1:0]      tl_q, tr_q;
  logic [GAIN_W-1:0]      g_l_q, g_r_q;
  logic [MW-1:0]          peak_l_q, peak_r_q;
  logic [MW-1:0]          meter_l_q, meter_r_q;
  logic [SAMPLE_BITS-1:0] res_l_q, res_r_q;
  logic [SINE_W-1:0]      rom_q;

  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_left_q, out_right_q;
  logic [MW-1:0]          out_meter_l_q, out_meter_r_q;

  logic                   in_acc;
  logic                   out_free;
  logic                   tgt_en;
  logic [15:0]            pan_u;
  logic [16+IW-1:0]       pan_scaled;
  logic [IW-1:0]          pan_idx;
  logic [IW-1:0]          rom_addr;

  logic [AW-1:0]          mul_a;
  logic [COEF_W-1:0]      mul_b;
  logic [PW-1:0]          prod;

  logic [PW:0]            tgt_sum;
  logic [GAIN_W-1:0]      tgt_d;
  logic [GAIN_W-1:0]      ad_t, ad_g, ad_diff;
  logic [GAIN_W-1:0]      sm_g, sm_t, smooth_d;
  logic [SAMPLE_BITS-1:0] mag_src, mag;
  logic [PW:0]            sc_sum;
  logic [PPW-1:0]         sc_p;
  logic                   sc_neg;
  logic [SAMPLE_BITS-1:0] sc_y;
  logic [MW-1:0]          sc_mag, peak_sel, peak_d;
  logic [MW-1:0]          dec, meter_peak, meter_d;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign tgt_en   = !mute_q && !((solo_q != '0) && !self_solo_q);

  // Pan index: offset pan to unsigned, scale to the table size.
  assign pan_u      = {~pan_q[15], pan_q[14:0]};
  assign pan_scaled = (16+IW)'(pan_u) * (16+IW)'(PAN_TABLE_ENTRIES);
  assign pan_idx    = pan_scaled[16 +: IW];
  assign rom_addr   = (state_q == ST_IDLE) ? pan_idx : IW'(PAN_TABLE_ENTRIES) - pan_idx;

  spgsm_mul #(
    .A_W (AW),
    .B_W (COEF_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Target gain from the table point times volume, rounded from Q3.30 to Q2.16.
  assign tgt_sum = {1'b0, prod} + (PW+1)'(8192);
  assign tgt_d   = tgt_en ? tgt_sum[14 +: GAIN_W] : '0;

  // Distance between target and gain, fed to the multiplier.
  assign ad_t    = (state_q == ST_SM_R) ? tr_q : tl_q;
  assign ad_g    = (state_q == ST_SM_R) ? g_r_q : g_l_q;
  assign ad_diff = (ad_t > ad_g) ? ad_t - ad_g : ad_g - ad_t;

  // Gain update one step after the distance went through the multiplier.
  assign sm_g     = (state_q == ST_SM_L) ? g_r_q : g_l_q;
  assign sm_t     = (state_q == ST_SM_L) ? tr_q : tl_q;
  assign smooth_d = smooth_step(sm_g, sm_t, prod[27:0]);

  // Sample magnitude for the scaling multiply.
  assign mag_src = (state_q == ST_SC_R) ? smp_r_q : smp_l_q;
  assign mag     = mag_src[SAMPLE_BITS-1] ? SAMPLE_BITS'(0) - mag_src : mag_src;

  // Scaled magnitude, rounded, then signed and saturated.
  assign sc_sum = {1'b0, prod} + (PW+1)'(32768);
  assign sc_p   = sc_sum[PW:16];
  assign sc_neg = (state_q == ST_SC_L) ? smp_r_q[SAMPLE_BITS-1] : smp_l_q[SAMPLE_BITS-1];

  always_comb begin
    if (sc_neg) begin
      sc_y = (sc_p > SMAX_P + PPW'(1)) ? {1'b1, {MW{1'b0}}}
                                       : SAMPLE_BITS'(PPW'(0) - sc_p);
    end else begin
      sc_y = (sc_p > SMAX_P) ? {1'b0, SMAX_M} : sc_p[SAMPLE_BITS-1:0];
    end
  end

  // The most negative output counts as the largest meter value.
  assign sc_mag   = (sc_p > SMAX_P) ? SMAX_M : sc_p[MW-1:0];
  assign peak_sel = (state_q == ST_SC_L) ? peak_r_q : peak_l_q;
  assign peak_d   = (sc_mag > peak_sel) ? sc_mag : peak_sel;

  // Meter: larger of the block peak and the decayed old meter.
  assign dec        = prod[16 +: MW];
  assign meter_peak = (state_q == ST_MT_L) ? peak_r_q : peak_l_q;
  assign meter_d    = (meter_peak > dec) ? meter_peak : dec;

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_TGT_R;
      ST_TGT_R:  state_d = ST_TGT_L;
      ST_TGT_L:  state_d = ST_SM_R;
      ST_SM_R:   state_d = ST_SM_L;
      ST_SM_L:   state_d = ST_SC_R;
      ST_SC_R:   state_d = ST_SC_L;
      ST_SC_L:   state_d = ST_MT_R;
      ST_MT_R:   state_d = last_q ? ST_MT_L : ST_OUT;
      ST_MT_L:   state_d = ST_MT_FIN;
      ST_MT_FIN: state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Multiplier operands per sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_TGT_R, ST_TGT_L: begin
        mul_a = AW'(rom_q);
        mul_b = COEF_W'(vol_q);
      end
      ST_SM_R, ST_SM_L: begin
        mul_a = AW'(ad_diff);
        mul_b = SMOOTH_COEF;
      end
      ST_SC_R: begin
        mul_a = AW'(mag);
        mul_b = g_r_q;
      end
      ST_SC_L: begin
        mul_a = AW'(mag);
        mul_b = g_l_q;
      end
      ST_MT_R: begin
        mul_a = AW'(meter_r_q);
        mul_b = DECAY_COEF;
      end
      ST_MT_L: begin
        mul_a = AW'(meter_l_q);
        mul_b = DECAY_COEF;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);

  // Control state, registers, gains, peaks and meters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vol_q       <= VOLUME_RESET;
      pan_q       <= '0;
      mute_q      <= 1'b0;
      solo_q      <= '0;
      self_solo_q <= 1'b0;
      g_l_q       <= '0;
      g_r_q       <= '0;
      peak_l_q    <= '0;
      peak_r_q    <= '0;
      meter_l_q   <= '0;
      meter_r_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_VOLUME:     vol_q       <= cfg_data_i;
          REG_PAN:        pan_q       <= cfg_data_i;
          REG_MUTE:       mute_q      <= cfg_data_i[0];
          REG_SOLO_COUNT: solo_q      <= cfg_data_i[7:0];
          REG_SELF_SOLO:  self_solo_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        ST_SM_L: g_r_q    <= smooth_d;
        ST_SC_R: g_l_q    <= smooth_d;
        ST_SC_L: peak_r_q <= peak_d;
        ST_MT_R: peak_l_q <= peak_d;
        ST_MT_L: meter_r_q <= meter_d;
        ST_MT_FIN: begin
          meter_l_q <= meter_d;
          peak_l_q  <= '0;
          peak_r_q  <= '0;
        end
        default: ;
      endcase
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working payload and output payload.
  always_ff @(posedge clk_i) begin
    rom_q <= sine_rom[rom_addr];
    if (in_acc) begin
      smp_l_q <= in_i.left_in;
      smp_r_q <= in_i.right_in;
      last_q  <= in_i.block_last;
    end
    case (state_q)
      ST_TGT_L: tr_q    <= tgt_d;
      ST_SM_R:  tl_q    <= tgt_d;
      ST_SC_L:  res_r_q <= sc_y;
      ST_MT_R:  res_l_q <= sc_y;
      default: ;
    endcase
    if (state_q == ST_OUT && out_free) begin
      out_left_q    <= res_l_q;
      out_right_q   <= res_r_q;
      out_meter_l_q <= meter_l_q;
      out_meter_r_q <= meter_r_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.left_out    = out_left_q;
  assign out_o.right_out   = out_right_q;
  assign out_o.meter_left  = out_meter_l_q;
  assign out_o.meter_right = out_meter_r_q;

  `SPGSM_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_i.ready, "input taken while busy")
  `SPGSM_ASSERT_NEXT(a_hold_on_stall, state_q == ST_OUT && out_valid_q && !out_o.ready, state_q == ST_OUT, "finished pair left the sequencer during a stall")
  `SPGSM_ASSERT_IMPL(a_silent_targets, state_q == ST_SM_L && !tgt_en, tl_q == '0 && tr_q == '0, "target gain not zero while silenced")

endmodule
